FILE: rtl/minimal_standard_lcg_range_draw_core_defines.svh
// Assertion macros used by the checker.
// Each macro expects clk and rst_n in scope.
`ifndef MINIMAL_STANDARD_LCG_RANGE_DRAW_CORE_DEFINES_SVH
`define MINIMAL_STANDARD_LCG_RANGE_DRAW_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MSLCG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MSLCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mslcg_pkg.sv
package mslcg_pkg;

  // Field widths
  localparam int VALUE_BITS = 16;
  localparam int STATE_BITS = 31;
  localparam int SPAN_BITS  = VALUE_BITS + 1;
  localparam int PROD_BITS  = SPAN_BITS + STATE_BITS;
  localparam int QSUM_BITS  = STATE_BITS + 1;
  localparam int CNT_BITS   = $clog2(SPAN_BITS);

  // Generator constants
  localparam int MUL_BITS     = 15;
  localparam int MUL_CNT_BITS = $clog2(MUL_BITS);
  localparam logic [STATE_BITS-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [MUL_BITS-1:0]   LCG_MUL  = 15'd16807;
  localparam logic [STATE_BITS-1:0] SEED_RST = 31'd1;

  // Operation codes
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RELOAD = 1'b1;

  typedef struct packed {
    logic                          op;
    logic signed [VALUE_BITS-1:0]  range_low;
    logic signed [VALUE_BITS-1:0]  range_high;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  drawn_value;
    logic [STATE_BITS-1:0]         raw_state;
    logic                          range_error;
  } out_item_t;

endpackage

FILE: rtl/minimal_standard_lcg_range_draw_core.sv
// Minimal standard generator (state' = 16807 * state mod 2^31-1) with an
// integer draw in [range_low, range_high], exactly floor(state * span /
// (2^31-1)) above range_low. A draw transfer returns one result: it runs the
// bit-serial modular multiply by 16807, hands the new state over, runs the
// bit-serial state * span product, applies the quotient correction and makes
// the final add into the output register. The input stalls for the whole draw
// and opens the cycle after the result is loaded, so no new draw is taken
// before the previous one is through; a draw that finishes while the previous
// result is still stalled in the output register waits in its last step until
// that result leaves. A reload transfer copies the seed register into the state
// and returns nothing. One draw is in flight at a time; a finished result may
// wait in the output register while the next item is taken. With range_low >
// range_high the draw returns range_low with range_error set, and the state
// still advances.
module minimal_standard_lcg_range_draw_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mslcg_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mslcg_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [mslcg_pkg::STATE_BITS-1:0]  cfg_wdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_QUOT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam int VB = mslcg_pkg::VALUE_BITS;
  localparam int SB = mslcg_pkg::STATE_BITS;
  localparam int PB = mslcg_pkg::PROD_BITS;
  localparam int NB = mslcg_pkg::SPAN_BITS;

  logic [2:0]                         fsm_r;
  logic [SB-1:0]                      seed_r;
  logic [SB-1:0]                      gen_state_r;
  logic signed [VB-1:0]               lo_r;
  logic [NB-1:0]                      span_r;
  logic                               err_r;
  logic [PB-1:0]                      prod_r, prod_nxt;
  logic [mslcg_pkg::CNT_BITS-1:0]     cnt_r;
  logic [NB-1:0]                      scaled_r;
  logic                               out_valid_r;
  mslcg_pkg::out_item_t               out_data_r;

  logic                               in_accept;
  logic                               out_free;
  logic                               step_start;
  logic                               step_done;
  logic [SB-1:0]                      step_state;
  logic [NB-1:0]                      span_in;
  logic                               err_in;
  logic [SB:0]                        add_sum;
  logic [NB-1:0]                      quot;
  logic [mslcg_pkg::QSUM_BITS-1:0]    qr_sum;
  logic                               qr_ge;

  assign in_stall   = (fsm_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign step_start = in_accept && (in_data.op == mslcg_pkg::OP_DRAW);

  mslcg_lcg_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (step_start),
    .state_in  (gen_state_r),
    .done      (step_done),
    .state_out (step_state)
  );

  // Span and empty-range flag from the input fields
  always_comb begin
    span_in = {in_data.range_high[VB-1], in_data.range_high}
            - {in_data.range_low[VB-1], in_data.range_low} + NB'(1);
    err_in  = in_data.range_low > in_data.range_high;
  end

  // Serial product: add the state when the low multiplier bit is set, shift right
  always_comb begin
    add_sum  = {1'b0, prod_r[PB-1:NB]} + (prod_r[0] ? {1'b0, gen_state_r} : '0);
    prod_nxt = {add_sum, prod_r[NB-1:1]};
  end

  // floor(P / (2^31-1)) = q + (q + r >= 2^31-1), with P = q*2^31 + r
  always_comb begin
    quot   = prod_r[PB-1:SB];
    qr_sum = {{(mslcg_pkg::QSUM_BITS-NB){1'b0}}, quot} + {1'b0, prod_r[SB-1:0]};
    qr_ge  = qr_sum >= {1'b0, mslcg_pkg::LCG_MOD};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= ST_IDLE;
      seed_r      <= mslcg_pkg::SEED_RST;
      gen_state_r <= mslcg_pkg::SEED_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      // Drop the result once it transfers, unless a new one is loaded now
      if (out_valid_r && !out_stall && fsm_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (fsm_r)
        ST_IDLE: begin
          if (in_accept) begin
            if (in_data.op == mslcg_pkg::OP_RELOAD) begin
              gen_state_r <= seed_r;
            end else begin
              fsm_r <= ST_STEP;
            end
          end
        end
        ST_STEP: begin
          if (step_done) begin
            gen_state_r <= step_state;
            fsm_r       <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (cnt_r == '0) begin
            fsm_r <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          fsm_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            fsm_r       <= ST_IDLE;
          end
        end
        default: begin
          fsm_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (step_start) begin
      lo_r   <= in_data.range_low;
      span_r <= span_in;
      err_r  <= err_in;
    end
    if (fsm_r == ST_STEP && step_done) begin
      prod_r <= {{SB{1'b0}}, span_r};
      cnt_r  <= mslcg_pkg::CNT_BITS'(NB - 1);
    end else if (fsm_r == ST_SCALE) begin
      prod_r <= prod_nxt;
      cnt_r  <= cnt_r - 1'b1;
    end
    if (fsm_r == ST_QUOT) begin
      scaled_r <= quot + {{(NB-1){1'b0}}, qr_ge};
    end
    // Load the result
    if (fsm_r == ST_FIN && out_free) begin
      out_data_r.drawn_value <= err_r ? lo_r : lo_r + $signed(scaled_r[VB-1:0]);
      out_data_r.raw_state   <= gen_state_r;
      out_data_r.range_error <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/mslcg_lcg_step.sv
module mslcg_lcg_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mslcg_pkg::STATE_BITS-1:0]  state_in,
  output logic                              done,
  output logic [mslcg_pkg::STATE_BITS-1:0]  state_out
);

  logic [mslcg_pkg::STATE_BITS-1:0]   acc_r, acc_nxt;
  logic [mslcg_pkg::STATE_BITS-1:0]   opnd_r;
  logic [mslcg_pkg::MUL_CNT_BITS-1:0] bit_cnt_r;
  logic                               run_r;
  logic                               done_r;

  logic [mslcg_pkg::STATE_BITS-1:0]   dbl;
  logic [mslcg_pkg::STATE_BITS-1:0]   addend;
  logic [mslcg_pkg::QSUM_BITS-1:0]    sum;
  logic [mslcg_pkg::STATE_BITS-1:0]   folded;

  // One multiplier bit per cycle, MSB first: acc = 2*acc + bit*opnd mod (2^31-1)
  always_comb begin
    dbl    = {acc_r[mslcg_pkg::STATE_BITS-2:0], acc_r[mslcg_pkg::STATE_BITS-1]};
    addend = mslcg_pkg::LCG_MUL[bit_cnt_r] ? opnd_r : '0;
    sum    = {1'b0, dbl} + {1'b0, addend};
    // fold the carry back in, since 2^31 is congruent to 1
    folded = sum[mslcg_pkg::STATE_BITS-1:0] +
             {{(mslcg_pkg::STATE_BITS-1){1'b0}}, sum[mslcg_pkg::STATE_BITS]};
    acc_nxt = (folded == mslcg_pkg::LCG_MOD) ? '0 : folded;
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        run_r  <= 1'b1;
        done_r <= 1'b0;
      end else if (run_r && bit_cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r     <= '0;
      opnd_r    <= state_in;
      bit_cnt_r <= mslcg_pkg::MUL_CNT_BITS'(mslcg_pkg::MUL_BITS - 1);
    end else if (run_r) begin
      acc_r     <= acc_nxt;
      bit_cnt_r <= bit_cnt_r - 1'b1;
    end
  end

  assign done      = done_r;
  assign state_out = acc_r;

endmodule

FILE: rtl/mslcg_checker.sv
`include "minimal_standard_lcg_range_draw_core_defines.svh"

module mslcg_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input mslcg_pkg::in_item_t   in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input mslcg_pkg::out_item_t  out_data
);

  // Hold a stalled result
  `MSLCG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // The generator never shows the fixed point 2^31-1
  `MSLCG_ASSERT_NOW(a_state_range, out_valid, out_data.raw_state != mslcg_pkg::LCG_MOD, "raw_state out of range")

  // A draw transfer keeps the block busy in the next cycle
  `MSLCG_ASSERT_NEXT(a_draw_busy, in_valid && !in_stall && in_data.op == mslcg_pkg::OP_DRAW, in_stall, "block idle after draw transfer")

  // A new result appears only at the end of a busy draw
  `MSLCG_ASSERT_NOW(a_out_after_work, $rose(out_valid), $past(in_stall), "result without draw in progress")

endmodule

bind minimal_standard_lcg_range_draw_core mslcg_checker u_mslcg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
